// ===== rtl/fedl_pkg.sv =====
// Shared types, constants and codes for the feedback echo delay line.
package fedl_pkg;

  localparam int DELAY_DEPTH = 131072;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int SAMPLE_W    = 16;
  localparam int CFG_W       = 17;
  localparam int CMP_W       = (ADDR_W > CFG_W) ? ADDR_W : CFG_W;
  localparam int APB_DW      = 32;
  localparam int CFG_AW      = 4;
  localparam int PROD1_W     = SAMPLE_W + CFG_W + 1;
  localparam int TRUNC1_W    = PROD1_W - 16;
  localparam int SUM_W       = TRUNC1_W + 1;
  localparam int PROD2_W     = SUM_W + CFG_W + 1;
  localparam int TRUNC2_W    = PROD2_W - 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [CFG_W-1:0]           cfg_val_t;
  typedef logic [1:0]                 reg_idx_t;

  localparam reg_idx_t REG_DELAY = 2'd0;
  localparam reg_idx_t REG_WET   = 2'd1;
  localparam reg_idx_t REG_SCALE = 2'd2;

  localparam cfg_val_t DELAY_RST = 17'd11025;
  localparam cfg_val_t WET_RST   = 17'd49152;
  localparam cfg_val_t SCALE_RST = 17'd37449;

  localparam addr_t LAST_ADDR = ADDR_W'(DELAY_DEPTH - 1);

  typedef struct packed {
    cfg_val_t delay_samples;
    cfg_val_t wet_gain;
    cfg_val_t output_scale;
  } cfg_t;

  typedef struct packed {
    logic ld_prod1;
    logic ld_prod2;
  } math_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_WRITE
  } state_t;

endpackage

// ===== rtl/fedl_ifs.sv =====
// Request channel interfaces for input and output samples.
interface fedl_in_if;
  logic              valid;
  logic              ready;
  fedl_pkg::sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fedl_out_if;
  logic              valid;
  logic              ready;
  fedl_pkg::sample_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/fedl_cfg_regs.sv =====
// APB configuration registers: delay, wet gain and output scale.
module fedl_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [fedl_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [fedl_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [fedl_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready,
  output fedl_pkg::cfg_t               cfg
);
  import fedl_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_DELAY: cfg_nxt.delay_samples = cfg_pwdata[CFG_W-1:0];
        REG_WET:   cfg_nxt.wet_gain      = cfg_pwdata[CFG_W-1:0];
        REG_SCALE: cfg_nxt.output_scale  = cfg_pwdata[CFG_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DELAY: cfg_prdata = APB_DW'(cfg_r.delay_samples);
      REG_WET:   cfg_prdata = APB_DW'(cfg_r.wet_gain);
      REG_SCALE: cfg_prdata = APB_DW'(cfg_r.output_scale);
      default:   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_samples <= DELAY_RST;
      cfg_r.wet_gain      <= WET_RST;
      cfg_r.output_scale  <= SCALE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/fedl_delay_ram.sv =====
// Single-port-write, registered-read delay memory.
module fedl_delay_ram #(
  parameter int ADDR_W = 17,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fedl_echo_math.sv =====
// Two-stage echo arithmetic: wet gain, mix, output scale and saturation.
module fedl_echo_math (
  input  logic                    clk,
  input  fedl_pkg::math_ctrl_t    ctrl,
  input  fedl_pkg::sample_t       delayed,
  input  fedl_pkg::sample_t       dry,
  input  fedl_pkg::cfg_val_t      wet_gain,
  input  fedl_pkg::cfg_val_t      output_scale,
  output fedl_pkg::sample_t       y_echo
);
  import fedl_pkg::*;

  logic signed [PROD1_W-1:0]  prod1_r;
  logic signed [PROD1_W-1:0]  prod1_nxt;
  logic signed [PROD1_W-1:0]  bias1;
  logic signed [TRUNC1_W-1:0] wet_part;
  logic signed [SUM_W-1:0]    mix;
  logic signed [PROD2_W-1:0]  prod2_r;
  logic signed [PROD2_W-1:0]  prod2_nxt;
  logic signed [PROD2_W-1:0]  bias2;
  logic signed [TRUNC2_W-1:0] scaled;

  // Truncation toward zero: bias negatives by 2^16-1 before the shift.
  assign prod1_nxt = PROD1_W'(delayed) * $signed({1'b0, wet_gain});
  assign bias1     = prod1_r + (prod1_r[PROD1_W-1] ? PROD1_W'(65535) : PROD1_W'(0));
  assign wet_part  = bias1[PROD1_W-1:16];
  assign mix       = SUM_W'(dry) + SUM_W'(wet_part);
  assign prod2_nxt = PROD2_W'(mix) * $signed({1'b0, output_scale});
  assign bias2     = prod2_r + (prod2_r[PROD2_W-1] ? PROD2_W'(65535) : PROD2_W'(0));
  assign scaled    = bias2[PROD2_W-1:16];

  always_comb begin
    if (scaled > TRUNC2_W'(32767)) begin
      y_echo = 16'sh7fff;
    end else if (scaled < -TRUNC2_W'(32768)) begin
      y_echo = 16'sh8000;
    end else begin
      y_echo = scaled[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_prod1) begin
      prod1_r <= prod1_nxt;
    end
    if (ctrl.ld_prod2) begin
      prod2_r <= prod2_nxt;
    end
  end

endmodule

// ===== rtl/feedback_echo_delay_line.sv =====
// Feedback echo delay line top level: sequencer, positions and output register.
//
// Input requests arrive on in_if (sample_in), results leave on out_if
// (sample_out), one result per request. Registers are written over the
// cfg_ APB port (0x0 delay_samples, 0x4 wet_gain, 0x8 output_scale); the user
// must do so only while no request is in flight, as the block does not check.
// Until the write position passes delay_samples each sample passes through;
// the sample that sees this arms the echo. After that each sample is mixed
// with the stored output read from the trailing read position, scaled and
// saturated, and the output itself is written back into the delay memory.
// In pass-through a request goes from idle straight to write back; once the
// echo runs it goes through memory read, gain multiply, scale multiply and
// write back. No new request is accepted until the sequencer is back in
// idle, and out_if.valid is registered from the write-back state.
// A finished result sits in the output register, and the next request is
// accepted while it waits; a stalled receiver holds the write-back stage.
// Reset (rst_n, synchronous) clears positions, the echo flag and restores
// register defaults; the delay memory is not cleared and needs no sweep.
module feedback_echo_delay_line (
  input  logic                         clk,
  input  logic                         rst_n,
  fedl_in_if.sink                      in_if,
  fedl_out_if.source                   out_if,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [fedl_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [fedl_pkg::APB_DW-1:0]  cfg_pwdata,
  output logic [fedl_pkg::APB_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import fedl_pkg::*;

  cfg_t       cfg;
  math_ctrl_t math_ctrl;
  state_t     state_r, state_nxt;
  addr_t      wp_r, rp_r;
  logic       echo_r, item_echo_r, out_valid_r;
  sample_t    x_r, out_data_r, y_echo, y, rdata;
  logic       in_acc, out_free, ram_re, ram_we, arm;

  fedl_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  fedl_delay_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (SAMPLE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (y),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (rdata)
  );

  fedl_echo_math u_math (
    .clk          (clk),
    .ctrl         (math_ctrl),
    .delayed      (rdata),
    .dry          (x_r),
    .wet_gain     (cfg.wet_gain),
    .output_scale (cfg.output_scale),
    .y_echo       (y_echo)
  );

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign arm      = !echo_r && (CMP_W'(wp_r) > CMP_W'(cfg.delay_samples));
  assign y        = item_echo_r ? y_echo : x_r;

  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_data_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_if.valid) state_nxt = echo_r ? ST_MUL1 : ST_WRITE;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_WRITE;
      ST_WRITE: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready        = 1'b0;
    ram_re             = 1'b0;
    ram_we             = 1'b0;
    math_ctrl.ld_prod1 = 1'b0;
    math_ctrl.ld_prod2 = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        ram_re      = in_if.valid && echo_r;
      end
      ST_MUL1:  math_ctrl.ld_prod1 = 1'b1;
      ST_MUL2:  math_ctrl.ld_prod2 = 1'b1;
      ST_WRITE: ram_we = out_free;
      default:  in_if.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      echo_r      <= 1'b0;
      item_echo_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        item_echo_r <= echo_r;
        if (echo_r) begin
          rp_r <= (rp_r == LAST_ADDR) ? '0 : rp_r + 1'b1;
        end
        if (arm) begin
          echo_r <= 1'b1;
        end
      end
      if (ram_we) begin
        wp_r        <= (wp_r == LAST_ADDR) ? '0 : wp_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_if.sample_in;
    end
    if (ram_we) begin
      out_data_r <= y;
    end
  end

  a_echo_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && echo_r) |=> (state_r == ST_MUL1))
    else $error("echo request did not enter multiply stage");

  a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_WRITE))
    else $error("result appeared outside write-back");

  a_echo_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    echo_r |=> echo_r)
    else $error("echo flag cleared without reset");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_acc)
    else $error("request accepted while busy");

endmodule

// ===== dv/feedback_echo_delay_line_tb.sv =====
// Testbench for the feedback echo delay line: scoreboard, request drivers and checks.
module feedback_echo_delay_line_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fedl_pkg::*;

  localparam int       CYCLE_LIMIT   = 800000;
  localparam int       SETTLE_CYCLES = 8;
  localparam int       HOLD_CYCLES   = 400;
  localparam int       PHASES        = 6;
  localparam int       PHASE_ITEMS   = 175;
  localparam reg_idx_t REG_UNUSED    = 2'd3;
  localparam cfg_val_t CFG_MAX       = 17'h1ffff;
  localparam cfg_val_t UNITY         = 17'd65536;
  localparam cfg_val_t HALF          = 17'd32768;

  class echo_scoreboard;
    sample_t     echo_mem [DELAY_DEPTH];
    int unsigned wr_pos;
    int unsigned rd_pos;
    bit          armed;
    cfg_val_t    delay_thr;
    cfg_val_t    wet;
    cfg_val_t    scale;
    sample_t     expected_q [$];
    int          errors;

    function new();
      wr_pos    = 0;
      rd_pos    = 0;
      armed     = 1'b0;
      delay_thr = DELAY_RST;
      wet       = WET_RST;
      scale     = SCALE_RST;
      errors    = 0;
    endfunction

    function void write_reg(reg_idx_t idx, cfg_val_t val);
      case (idx)
        REG_DELAY: delay_thr = val;
        REG_WET:   wet = val;
        REG_SCALE: scale = val;
        default: ;
      endcase
    endfunction

    // Predicts the result of one accepted input request.
    function void note_sample(sample_t x);
      longint xi;
      longint d;
      longint w;
      longint s;
      longint acc;
      longint y;
      xi = x;
      y  = xi;
      if (armed) begin
        d   = echo_mem[rd_pos];
        w   = wet;
        s   = scale;
        acc = xi + (d * w) / 65536;
        y   = (acc * s) / 65536;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        rd_pos = (rd_pos + 1) % DELAY_DEPTH;
      end else if (wr_pos > delay_thr) begin
        armed = 1'b1;
      end
      echo_mem[wr_pos] = sample_t'(y);
      wr_pos = (wr_pos + 1) % DELAY_DEPTH;
      expected_q.push_back(sample_t'(y));
    endfunction

    function void check_sample(sample_t got);
      sample_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected sample_out, expected none, actual %0d", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic cfg_pready;

  fedl_in_if  in_bus ();
  fedl_out_if out_bus ();

  echo_scoreboard sb = new();
  bit steady;
  bit hold_pending;
  int cycles;

  feedback_echo_delay_line dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_bus),
    .out_if      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("feedback_echo_delay_line test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      sb.check_sample(out_bus.sample_out);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 15))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic write_reg(input reg_idx_t idx, input cfg_val_t val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= APB_DW'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_sample(input sample_t s);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.sample_in <= s;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result sink: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = steady ? 0 : pick_gap();
        if (stall > 0) begin
          out_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
    end
  end

  initial begin
    sample_t pass_set [11];
    sample_t echo_set [11];
    cfg_val_t w;
    cfg_val_t sc;
    pass_set = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001, 16'sh5555,
                 16'shaaaa, 16'sh7ffe, 16'sh8001, 16'sh00ff, 16'shff00};
    echo_set = '{16'sh1234, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    steady       = 1'b0;
    hold_pending = 1'b0;
    cycles       <= 0;
    rst_n        <= 1'b0;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.sample_in <= '0;
    out_bus.ready    <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // largest delay: pure pass-through
    write_reg(REG_DELAY, CFG_MAX);
    write_reg(REG_WET, UNITY);
    write_reg(REG_SCALE, UNITY);
    foreach (pass_set[i]) send_sample(pass_set[i]);
    drain();

    // zero delay arms on the next request; unity gains drive saturation
    write_reg(REG_DELAY, '0);
    write_reg(REG_UNUSED, cfg_val_t'($urandom));
    foreach (echo_set[i]) send_sample(echo_set[i]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin w = '0; sc = HALF; end
        1: begin w = CFG_MAX; sc = CFG_MAX; end
        2: begin
          w  = cfg_val_t'($urandom_range(0, UNITY));
          sc = cfg_val_t'($urandom_range(HALF, UNITY));
        end
        3: begin w = UNITY; sc = UNITY; end
        4: begin w = cfg_val_t'($urandom); sc = cfg_val_t'($urandom); end
        default: begin w = WET_RST; sc = SCALE_RST; end
      endcase
      // delay is ignored once the echo runs
      case (p)
        0: write_reg(REG_DELAY, CFG_MAX);
        1: write_reg(REG_DELAY, '0);
        default: write_reg(REG_DELAY, cfg_val_t'($urandom));
      endcase
      write_reg(REG_WET, w);
      write_reg(REG_SCALE, sc);
      if (p == 4) write_reg(REG_UNUSED, cfg_val_t'($urandom));
      steady = (p == 1 || p == 2);
      hold_pending = (p == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) send_sample(rand_sample());
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("feedback_echo_delay_line test passed");
    end else begin
      $display("feedback_echo_delay_line test failed");
    end
    $finish;
  end

endmodule
